>>> design/krt_pkg.sv
// shared types and constants for the keyed record table
`timescale 1ns / 1ps

package krt_pkg;

    // table geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // request and response field widths
    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } krt_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } krt_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_DONE
    } krt_state_t;

    // one table record as stored in memory
    typedef struct packed {
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] quantity;
        logic        [WORD_W-1:0] price;
    } krt_entry_t;

    localparam int ENTRY_W = $bits(krt_entry_t);

endpackage

>>> design/krt_if.sv
// request and response channel interfaces of the keyed record table
`timescale 1ns / 1ps

interface krt_req_if;
    logic                               valid;
    logic                               ready;
    logic [krt_pkg::OP_W-1:0]           operation;
    logic signed [krt_pkg::WORD_W-1:0]  key;
    logic signed [krt_pkg::WORD_W-1:0]  quantity;
    logic [krt_pkg::WORD_W-1:0]         price_word;
    logic [krt_pkg::POS_W-1:0]          position;

    modport source (
        output valid, operation, key, quantity, price_word, position,
        input  ready
    );

    modport sink (
        input  valid, operation, key, quantity, price_word, position,
        output ready
    );
endinterface

interface krt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [krt_pkg::STATUS_W-1:0]       status;
    logic signed [krt_pkg::WORD_W-1:0]  entry_key;
    logic signed [krt_pkg::WORD_W-1:0]  entry_quantity;
    logic [krt_pkg::WORD_W-1:0]         entry_price;
    logic [krt_pkg::COUNT_W-1:0]        entry_count;

    modport source (
        output valid, status, entry_key, entry_quantity, entry_price, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, entry_key, entry_quantity, entry_price, entry_count,
        output ready
    );
endinterface

>>> design/krt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/keyed_record_table_core.sv
// top level of the keyed record table: control sequencer around one record ram
`timescale 1ns / 1ps

// Keyed record table. Holds up to CAPACITY packed records (key, quantity,
// price word) in one ram of full records with a registered read. One request
// is worked at a time; the request channel is ready only while the sequencer
// is idle, and a finished response waits in an output register so the next
// request can be taken before the response is drained. Timing is set by the
// single ram read port, which walks the table one entry per cycle: a read in
// range passes through S_READ, a read beyond the count, a refused insert or a
// request on an empty table goes straight to S_DONE, a key search scans from
// entry zero up to the key or the last entry, and a delete then shifts the
// later entries down one place; any request may also wait in S_DONE for the
// output register to drain. No clearing pass is needed after reset; entries
// at or above the count are never read back.
module keyed_record_table_core (
    input  logic      clk,
    input  logic      rst_n,
    krt_req_if.sink   req,
    krt_rsp_if.source rsp
);

    import krt_pkg::*;

    krt_state_t               state_reg;
    krt_state_t               state_next;
    krt_op_t                  op_reg;
    logic signed [WORD_W-1:0] key_reg;
    logic signed [WORD_W-1:0] qty_reg;
    logic [WORD_W-1:0]        price_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         idx_next;

    // pending response, built while the request is worked
    krt_status_t              pend_status_reg;
    krt_status_t              pend_status_next;
    krt_entry_t               pend_entry_reg;
    krt_entry_t               pend_entry_next;

    // output register
    logic                     out_valid_reg;
    krt_status_t              out_status_reg;
    krt_entry_t               out_entry_reg;
    logic [CNT_W-1:0]         out_count_reg;

    // ram port signals
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    krt_entry_t               wr_entry;
    logic [IDX_W-1:0]         rd_addr;
    logic [ENTRY_W-1:0]       rd_data;
    krt_entry_t               rd_entry;

    // decode helpers
    logic                     req_fire;
    logic                     out_free;
    logic                     out_load;
    krt_op_t                  req_op;
    logic                     tbl_full;
    logic                     tbl_empty;
    logic                     pos_bad;
    logic                     scan_match;
    logic                     scan_last;
    logic                     shift_last;
    krt_entry_t               req_entry;
    krt_entry_t               zero_entry;

    // record ram
    krt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry   = krt_entry_t'(rd_data);
    assign zero_entry = '0;

    // handshake and decode
    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign req_op     = krt_op_t'(req.operation);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign out_load   = (state_reg == S_DONE) && out_free;
    assign tbl_full   = (count_reg == CNT_W'(CAPACITY));
    assign tbl_empty  = (count_reg == '0);
    assign pos_bad    = (CNT_W'(req.position) >= count_reg);
    assign scan_match = (rd_entry.key == key_reg);
    assign scan_last  = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign shift_last = (CNT_W'(idx_reg) == count_reg - CNT_W'(2));

    assign req_entry.key      = req.key;
    assign req_entry.quantity = req.quantity;
    assign req_entry.price    = req.price_word;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_op)
                        OP_INSERT:
                        begin
                            state_next = (tbl_full || tbl_empty) ? S_DONE : S_SCAN;
                        end
                        OP_UPDATE, OP_DELETE:
                        begin
                            state_next = tbl_empty ? S_DONE : S_SCAN;
                        end
                        OP_READ:
                        begin
                            state_next = pos_bad ? S_DONE : S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_match && (op_reg == OP_DELETE) && !scan_last)
                begin
                    state_next = S_SHIFT;
                end
                else if (scan_match || scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        rd_addr          = idx_reg + IDX_W'(1);
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_entry         = rd_entry;
        idx_next         = idx_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_entry_next  = pend_entry_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // first scan read at entry zero, or the requested position
                rd_addr  = (req_op == OP_READ) ? IDX_W'(req.position) : '0;
                idx_next = '0;
                if (req_fire)
                begin
                    unique case (req_op)
                        OP_INSERT:
                        begin
                            if (tbl_full)
                            begin
                                pend_status_next = ST_FULL;
                                pend_entry_next  = zero_entry;
                            end
                            else if (tbl_empty)
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = '0;
                                wr_entry         = req_entry;
                                count_next       = CNT_W'(1);
                                pend_status_next = ST_OK;
                                pend_entry_next  = req_entry;
                            end
                        end
                        OP_UPDATE, OP_DELETE:
                        begin
                            if (tbl_empty)
                            begin
                                pend_status_next = ST_NOTFOUND;
                                pend_entry_next  = zero_entry;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_bad)
                            begin
                                pend_status_next = ST_BADPOS;
                                pend_entry_next  = zero_entry;
                            end
                        end
                        default:
                        begin
                            pend_status_next = pend_status_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // compare the entry read last cycle, read the next one
                idx_next = idx_reg + IDX_W'(1);
                if (scan_match)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            pend_status_next = ST_DUP;
                            pend_entry_next  = rd_entry;
                        end
                        OP_UPDATE:
                        begin
                            wr_en                    = 1'b1;
                            wr_entry.quantity        = qty_reg;
                            pend_status_next         = ST_OK;
                            pend_entry_next          = rd_entry;
                            pend_entry_next.quantity = qty_reg;
                        end
                        OP_DELETE:
                        begin
                            idx_next         = idx_reg;
                            pend_status_next = ST_OK;
                            pend_entry_next  = rd_entry;
                            if (scan_last)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            pend_status_next = pend_status_reg;
                        end
                    endcase
                end
                else if (scan_last)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        // key absent: append at the end
                        wr_en                    = 1'b1;
                        wr_addr                  = count_reg[IDX_W-1:0];
                        wr_entry.key             = key_reg;
                        wr_entry.quantity        = qty_reg;
                        wr_entry.price           = price_reg;
                        count_next               = count_reg + CNT_W'(1);
                        pend_status_next         = ST_OK;
                        pend_entry_next.key      = key_reg;
                        pend_entry_next.quantity = qty_reg;
                        pend_entry_next.price    = price_reg;
                    end
                    else
                    begin
                        pend_status_next = ST_NOTFOUND;
                        pend_entry_next  = zero_entry;
                    end
                end
            end
            S_SHIFT:
            begin
                // move entry idx+1 down to idx, read ahead at idx+2
                rd_addr  = idx_reg + IDX_W'(2);
                wr_en    = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (shift_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_READ:
            begin
                pend_status_next = ST_OK;
                pend_entry_next  = rd_entry;
            end
            S_DONE:
            begin
                rd_addr = idx_reg;
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and working registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= req_op;
            key_reg   <= req.key;
            qty_reg   <= req.quantity;
            price_reg <= req.price_word;
        end
        idx_reg         <= idx_next;
        pend_status_reg <= pend_status_next;
        pend_entry_reg  <= pend_entry_next;
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_entry_reg  <= pend_entry_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.entry_key      = out_entry_reg.key;
    assign rsp.entry_quantity = out_entry_reg.quantity;
    assign rsp.entry_price    = out_entry_reg.price;
    assign rsp.entry_count    = COUNT_W'(out_count_reg);

`ifndef ASSERT_OFF
    // the count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("record count beyond capacity");

    // the count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_W'(1)) ||
             (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("record count jumped");

    // every ram write lands inside the packed region
    a_write_packed: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CNT_W'(wr_addr) < count_next))
        else $error("ram write outside valid entries");

    // a response is only loaded when the slot is free
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_status_reg)))
        else $error("pending response overwritten");
`endif

endmodule
